/* hdl/rcci_pkg.sv */
// shared types, constants and saturation helper for the capped cylinder intersector
`timescale 1ns / 1ps

package rcci_pkg;

  localparam int NUM_W    = 34;
  localparam int DIV_LAT  = 35;
  localparam int SQRT_LAT = 32;
  localparam int CFG_AW   = 3;

  typedef enum logic [1:0] {
    HIT_NONE    = 2'd0,
    HIT_OUTSIDE = 2'd1,
    HIT_INSIDE  = 2'd2
  } hit_kind_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_CENTER_X       = 3'd0,
    REG_CENTER_Y       = 3'd1,
    REG_CENTER_Z       = 3'd2,
    REG_HALF_HEIGHT    = 3'd3,
    REG_RADIUS_SQUARED = 3'd4,
    REG_MAX_DISTANCE   = 3'd5
  } cfg_reg_e;

  function automatic logic signed [31:0] sat_s32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/rcci_delay.sv */
// enabled shift-register delay line
`timescale 1ns / 1ps

module rcci_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) pipe_q[i] <= '0;
    end else if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < N; i++) pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[N-1];

endmodule

/* hdl/rcci_div.sv */
// pipelined restoring divider, fixed point quotient saturated to 32 bits
`timescale 1ns / 1ps

module rcci_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [rcci_pkg::NUM_W-1:0] num_i,
  input  logic signed [31:0]                den_i,
  output logic signed [31:0]                quo_o
);

  localparam int NW = rcci_pkg::NUM_W;
  localparam int RW = NW + FRAC_BITS;
  localparam int CW = (RW > 64) ? RW : 64;
  localparam int QB = 32;

  logic [NW-1:0] mag_n;
  logic [31:0]   mag_d;
  logic [CW-1:0] p_rem_q, o_rem_q;
  logic [31:0]   p_dmag_q, o_dmag_q;
  logic          p_neg_q, o_neg_q, o_ovf_q;

  logic [CW-1:0] rem_q  [QB-1];
  logic [31:0]   dmag_q [QB-1];
  logic [QB-1:0] quo_q  [QB];
  logic          neg_q  [QB];
  logic          ovf_q  [QB];
  logic signed [31:0] quo_out_q;

  assign mag_n = num_i[NW-1] ? NW'(0 - num_i) : num_i;
  assign mag_d = den_i[31] ? (32'd0 - den_i) : den_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rem_q  <= CW'(mag_n) << FRAC_BITS;
      p_dmag_q <= mag_d;
      p_neg_q  <= num_i[NW-1] ^ den_i[31];
      o_rem_q  <= p_rem_q;
      o_dmag_q <= p_dmag_q;
      o_neg_q  <= p_neg_q;
      o_ovf_q  <= p_rem_q >= (CW'(p_dmag_q) << QB);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [CW-1:0] rem_in, sub, rem_d;
    logic [31:0]   dmag_in;
    logic [QB-1:0] quo_in, quo_d;
    logic          neg_in, ovf_in, ge;

    if (k == 0) begin : g_first
      assign rem_in  = o_rem_q;
      assign dmag_in = o_dmag_q;
      assign quo_in  = '0;
      assign neg_in  = o_neg_q;
      assign ovf_in  = o_ovf_q;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign dmag_in = dmag_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign ovf_in  = ovf_q[k-1];
    end

    assign sub   = CW'(dmag_in) << (QB - 1 - k);
    assign ge    = rem_in >= sub;
    assign rem_d = ge ? (rem_in - sub) : rem_in;

    always_comb begin
      quo_d = quo_in;
      quo_d[QB-1-k] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= quo_d;
        neg_q[k] <= neg_in;
        ovf_q[k] <= ovf_in;
      end
    end

    if (k < QB - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k]  <= rem_d;
          dmag_q[k] <= dmag_in;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!neg_q[QB-1]) begin
        if (ovf_q[QB-1] || quo_q[QB-1][31]) quo_out_q <= 32'sh7fffffff;
        else                                quo_out_q <= $signed(quo_q[QB-1]);
      end else begin
        if (ovf_q[QB-1] || (quo_q[QB-1] > 32'h80000000)) quo_out_q <= 32'sh80000000;
        else quo_out_q <= $signed(32'd0 - quo_q[QB-1]);
      end
    end
  end

  assign quo_o = quo_out_q;

endmodule

/* hdl/rcci_sqrt.sv */
// pipelined floor square root of a 64-bit value, one result bit per stage
`timescale 1ns / 1ps

module rcci_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] val_i,
  output logic [31:0] root_o
);

  localparam int S = rcci_pkg::SQRT_LAT;

  logic [63:0] v_q [S-1];
  logic [63:0] r_q [S];

  for (genvar k = 0; k < S; k++) begin : g_step
    logic [63:0] v_in, r_in, bitv, trial, v_d, r_d;

    if (k == 0) begin : g_first
      assign v_in = val_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign bitv  = 64'd1 << (62 - 2 * k);
    assign trial = r_in + bitv;

    always_comb begin
      if (v_in >= trial) begin
        v_d = v_in - trial;
        r_d = (r_in >> 1) + bitv;
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) r_q[k] <= r_d;
    end

    if (k < S - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) v_q[k] <= v_d;
      end
    end
  end

  assign root_o = r_q[S-1][31:0];

endmodule

/* hdl/ray_capped_cylinder_intersect.sv */
// top level: ray versus z-aligned capped cylinder intersection pipeline
// usage:
//   s_axis carries one ray per transaction (origin, direction, nearest distance),
//   m_axis returns one result per ray: hit kind on tuser, new distance on tdata.
//   cfg_* writes the cylinder registers; cfg_ready_o is always high. Writes must
//   be made only while no ray is in flight; the block itself does not enforce this.
// throughput: one ray per cycle while the pipeline is not stalled; the depth comes
//   from the 32-stage square root and the 35-stage divider in series on the side path.
// stall: the whole pipeline moves on a common enable; one skid register behind
//   the output register takes a result that arrives while the output waits, and
//   s_axis_tready drops while that skid register is full.
// reset: valid bits, including the output and skid valid flags, are cleared; registers
//   go to center 0, half height 1.0, radius squared 1.0.
`timescale 1ns / 1ps

module ray_capped_cylinder_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, nearest_distance, pad
  input  logic [223:0]                     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // hit_distance, pad
  output logic [31:0]                      m_axis_tdata,
  // hit_kind
  output logic [1:0]                       m_axis_tuser,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rcci_pkg::CFG_AW-1:0]      cfg_addr_i,
  input  logic [31:0]                      cfg_data_i
);

  localparam int WW = 64 - FRAC_BITS;
  localparam int DL = rcci_pkg::DIV_LAT;
  localparam int SL = rcci_pkg::SQRT_LAT;
  localparam int NW = rcci_pkg::NUM_W;

  function automatic logic signed [WW-1:0] mulw(input logic signed [63:0] p);
    logic [63:0]        bias;
    logic signed [63:0] s;
    bias = p[63] ? ((64'd1 << FRAC_BITS) - 64'd1) : 64'd0;
    s    = p + $signed(bias);
    return s[63:FRAC_BITS];
  endfunction

  // configuration
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [30:0]        hh_q, r2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
      hh_q <= 31'(64'd1 << FRAC_BITS);
      r2_q <= 31'(64'd1 << FRAC_BITS);
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        rcci_pkg::REG_CENTER_X:       cx_q <= cfg_data_i;
        rcci_pkg::REG_CENTER_Y:       cy_q <= cfg_data_i;
        rcci_pkg::REG_CENTER_Z:       cz_q <= cfg_data_i;
        rcci_pkg::REG_HALF_HEIGHT:    hh_q <= cfg_data_i[30:0];
        rcci_pkg::REG_RADIUS_SQUARED: r2_q <= cfg_data_i[30:0];
        rcci_pkg::REG_MAX_DISTANCE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // flow control
  logic en;
  logic out_v_q, skid_v_q;
  assign en            = ~skid_v_q;
  assign s_axis_tready = en;

  // stage 1: origin relative to center
  logic               v1_q;
  logic signed [31:0] ox1_q, oy1_q, oz1_q, dx1_q, dy1_q, dz1_q;
  logic [30:0]        ad1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox1_q <= rcci_pkg::sat_s32(66'($signed(s_axis_tdata[31:0])) - 66'(cx_q));
      oy1_q <= rcci_pkg::sat_s32(66'($signed(s_axis_tdata[63:32])) - 66'(cy_q));
      oz1_q <= rcci_pkg::sat_s32(66'($signed(s_axis_tdata[95:64])) - 66'(cz_q));
      dx1_q <= $signed(s_axis_tdata[127:96]);
      dy1_q <= $signed(s_axis_tdata[159:128]);
      dz1_q <= $signed(s_axis_tdata[191:160]);
      ad1_q <= s_axis_tdata[222:192];
    end
  end

  // stage 2: side products, cap numerators
  logic signed [63:0] m_dxdx2_q, m_dydy2_q, m_oxdx2_q, m_oydy2_q, m_oxox2_q, m_oyoy2_q;
  logic signed [NW-1:0] nh2_q, nl2_q;
  logic signed [31:0]   dz2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_dxdx2_q <= 64'(dx1_q) * 64'(dx1_q);
      m_dydy2_q <= 64'(dy1_q) * 64'(dy1_q);
      m_oxdx2_q <= 64'(ox1_q) * 64'(dx1_q);
      m_oydy2_q <= 64'(oy1_q) * 64'(dy1_q);
      m_oxox2_q <= 64'(ox1_q) * 64'(ox1_q);
      m_oyoy2_q <= 64'(oy1_q) * 64'(oy1_q);
      nh2_q     <= $signed({3'b000, hh_q}) - NW'(oz1_q);
      nl2_q     <= -$signed({3'b000, hh_q}) - NW'(oz1_q);
      dz2_q     <= dz1_q;
    end
  end

  // stage 3: product scaling
  logic signed [WW-1:0] w_dxdx3_q, w_dydy3_q, w_oxdx3_q, w_oydy3_q, w_oxox3_q, w_oyoy3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_dxdx3_q <= mulw(m_dxdx2_q);
      w_dydy3_q <= mulw(m_dydy2_q);
      w_oxdx3_q <= mulw(m_oxdx2_q);
      w_oydy3_q <= mulw(m_oydy2_q);
      w_oxox3_q <= mulw(m_oxox2_q);
      w_oyoy3_q <= mulw(m_oyoy2_q);
    end
  end

  // stage 4: quadratic coefficients
  logic signed [31:0] a4_q, b4_q, c4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a4_q <= rcci_pkg::sat_s32(66'(w_dxdx3_q) + 66'(w_dydy3_q));
      b4_q <= rcci_pkg::sat_s32(66'(w_oxdx3_q) + 66'(w_oydy3_q));
      c4_q <= rcci_pkg::sat_s32(66'(w_oxox3_q) + 66'(w_oyoy3_q)
                                - $signed(66'({1'b0, r2_q})));
    end
  end

  // stage 5 and 6: discriminant
  logic signed [63:0] bb5_q, ac5_q;
  logic               anz5_q;
  logic [63:0]        disc6_q;
  logic               sok6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bb5_q  <= 64'(b4_q) * 64'(b4_q);
      ac5_q  <= 64'(a4_q) * 64'(c4_q);
      anz5_q <= a4_q != 32'sd0;
      if (ac5_q <= 64'sd0) begin
        disc6_q <= 64'(bb5_q) + 64'(64'sd0 - ac5_q);
        sok6_q  <= anz5_q;
      end else begin
        disc6_q <= 64'(bb5_q - ac5_q);
        sok6_q  <= anz5_q && (bb5_q >= ac5_q);
      end
    end
  end

  // square root, result at stage 38
  logic [31:0] q38;
  rcci_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (disc6_q),
    .root_o (q38)
  );

  logic [63:0] ab38;
  rcci_delay #(.W(64), .N(SL + 2)) u_dly_ab (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .d_i ({a4_q, b4_q}), .q_o (ab38)
  );

  // stage 39: side root numerators
  logic signed [NW-1:0] n0_39_q, n1_39_q;
  logic signed [31:0]   a39_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n0_39_q <= -NW'($signed(ab38[31:0])) - $signed({2'b00, q38});
      n1_39_q <= -NW'($signed(ab38[31:0])) + $signed({2'b00, q38});
      a39_q   <= $signed(ab38[63:32]);
    end
  end

  logic signed [31:0] t0_74, t1_74;
  rcci_div #(.FRAC_BITS(FRAC_BITS)) u_div_t0 (
    .clk_i (clk_i), .en_i (en), .num_i (n0_39_q), .den_i (a39_q), .quo_o (t0_74)
  );
  rcci_div #(.FRAC_BITS(FRAC_BITS)) u_div_t1 (
    .clk_i (clk_i), .en_i (en), .num_i (n1_39_q), .den_i (a39_q), .quo_o (t1_74)
  );

  logic sok74;
  rcci_delay #(.W(1), .N(SL + DL + 1)) u_dly_sok (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (sok6_q), .q_o (sok74)
  );

  logic [30:0] ad74;
  rcci_delay #(.W(31), .N(SL + DL + 6)) u_dly_ad74 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (ad1_q), .q_o (ad74)
  );

  logic [31:0] dz75;
  rcci_delay #(.W(32), .N(SL + DL + 7)) u_dly_dz (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (dz1_q), .q_o (dz75)
  );

  logic [31:0] oz77;
  rcci_delay #(.W(32), .N(SL + DL + 9)) u_dly_oz (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (oz1_q), .q_o (oz77)
  );

  // stages 75 to 79: side height check
  logic signed [31:0]  st75_q, st76_q, st77_q, st78_q, st79_q;
  logic                spre75_q, spre76_q, spre77_q, spre78_q;
  rcci_pkg::hit_kind_e sk75_q, sk76_q, sk77_q, sk78_q, sk79_q;
  logic signed [63:0]  zp76_q;
  logic signed [WW-1:0] zw77_q;
  logic signed [31:0]  z78_q;
  logic signed [31:0]  ad74_s;
  logic [32:0]         zmag;

  assign ad74_s = $signed({1'b0, ad74});
  assign zmag   = z78_q[31] ? (33'd0 - 33'(z78_q)) : 33'(z78_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (t0_74 < 32'sd0) begin
        st75_q   <= t1_74;
        spre75_q <= sok74 && (t1_74 >= 32'sd0) && (t1_74 < ad74_s);
        sk75_q   <= rcci_pkg::HIT_INSIDE;
      end else begin
        st75_q   <= t0_74;
        spre75_q <= sok74 && (t0_74 < ad74_s);
        sk75_q   <= rcci_pkg::HIT_OUTSIDE;
      end
      zp76_q   <= 64'(st75_q) * 64'($signed(dz75));
      st76_q   <= st75_q;
      spre76_q <= spre75_q;
      sk76_q   <= sk75_q;
      zw77_q   <= mulw(zp76_q);
      st77_q   <= st76_q;
      spre77_q <= spre76_q;
      sk77_q   <= sk76_q;
      z78_q    <= rcci_pkg::sat_s32(66'($signed(oz77))
                                    + 66'(rcci_pkg::sat_s32(66'(zw77_q))));
      st78_q   <= st77_q;
      spre78_q <= spre77_q;
      sk78_q   <= sk77_q;
      st79_q   <= st78_q;
      sk79_q   <= (spre78_q && (zmag <= 33'(hh_q))) ? sk78_q : rcci_pkg::HIT_NONE;
    end
  end

  // cap path: dividers from stage 2, result at stage 37
  logic signed [31:0] t2_37, t3_37;
  rcci_div #(.FRAC_BITS(FRAC_BITS)) u_div_t2 (
    .clk_i (clk_i), .en_i (en), .num_i (nh2_q), .den_i (dz2_q), .quo_o (t2_37)
  );
  rcci_div #(.FRAC_BITS(FRAC_BITS)) u_div_t3 (
    .clk_i (clk_i), .en_i (en), .num_i (nl2_q), .den_i (dz2_q), .quo_o (t3_37)
  );

  logic [95:0] cap38;
  rcci_delay #(.W(96), .N(DL + 2)) u_dly_cap (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .d_i ({dz1_q != 32'sd0, ad1_q, dx1_q, dy1_q}), .q_o (cap38)
  );

  logic [63:0] oxy41;
  rcci_delay #(.W(64), .N(DL + 5)) u_dly_oxy (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .d_i ({ox1_q, oy1_q}), .q_o (oxy41)
  );

  logic signed [31:0]  tlo38_q, thi38_q;
  logic signed [31:0]  ad38_s;
  logic signed [31:0]  ct39_q, ct40_q, ct41_q, ct42_q, ct43_q, ct44_q;
  logic                cpre39_q, cpre40_q, cpre41_q, cpre42_q, cpre43_q;
  rcci_pkg::hit_kind_e ck39_q, ck40_q, ck41_q, ck42_q, ck43_q, ck44_q;
  logic signed [31:0]  dx39_q, dy39_q;
  logic signed [63:0]  mx40_q, my40_q;
  logic signed [WW-1:0] wx41_q, wy41_q;
  logic signed [31:0]  px42_q, py42_q;
  logic signed [63:0]  sx43_q, sy43_q;
  logic [WW-1:0]       rsum;

  assign ad38_s = $signed({1'b0, cap38[94:64]});
  assign rsum   = WW'(sx43_q[62:FRAC_BITS]) + WW'(sy43_q[62:FRAC_BITS]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      tlo38_q <= (t2_37 > t3_37) ? t3_37 : t2_37;
      thi38_q <= (t2_37 > t3_37) ? t2_37 : t3_37;
      if (tlo38_q < 32'sd0) begin
        ct39_q   <= thi38_q;
        cpre39_q <= cap38[95] && (thi38_q > 32'sd0) && (thi38_q < ad38_s);
        ck39_q   <= rcci_pkg::HIT_INSIDE;
      end else begin
        ct39_q   <= tlo38_q;
        cpre39_q <= cap38[95] && (tlo38_q < ad38_s);
        ck39_q   <= rcci_pkg::HIT_OUTSIDE;
      end
      dx39_q   <= $signed(cap38[63:32]);
      dy39_q   <= $signed(cap38[31:0]);
      mx40_q   <= 64'(dx39_q) * 64'(ct39_q);
      my40_q   <= 64'(dy39_q) * 64'(ct39_q);
      ct40_q   <= ct39_q;
      cpre40_q <= cpre39_q;
      ck40_q   <= ck39_q;
      wx41_q   <= mulw(mx40_q);
      wy41_q   <= mulw(my40_q);
      ct41_q   <= ct40_q;
      cpre41_q <= cpre40_q;
      ck41_q   <= ck40_q;
      px42_q   <= rcci_pkg::sat_s32(66'($signed(oxy41[63:32]))
                                    + 66'(rcci_pkg::sat_s32(66'(wx41_q))));
      py42_q   <= rcci_pkg::sat_s32(66'($signed(oxy41[31:0]))
                                    + 66'(rcci_pkg::sat_s32(66'(wy41_q))));
      ct42_q   <= ct41_q;
      cpre42_q <= cpre41_q;
      ck42_q   <= ck41_q;
      sx43_q   <= 64'(px42_q) * 64'(px42_q);
      sy43_q   <= 64'(py42_q) * 64'(py42_q);
      ct43_q   <= ct42_q;
      cpre43_q <= cpre42_q;
      ck43_q   <= ck42_q;
      ct44_q   <= ct43_q;
      ck44_q   <= (cpre43_q && (rsum < WW'(r2_q))) ? ck43_q : rcci_pkg::HIT_NONE;
    end
  end

  logic [33:0] cap79;
  rcci_delay #(.W(34), .N(SL + 3)) u_dly_cres (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .d_i ({ck44_q, ct44_q}), .q_o (cap79)
  );

  logic [31:0] vad79;
  rcci_delay #(.W(32), .N(SL + DL + 11)) u_dly_vad (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .d_i ({v1_q, ad1_q}), .q_o (vad79)
  );

  // merge of cap and side hits
  rcci_pkg::hit_kind_e ck79, fin_kind;
  logic signed [31:0]  ct79;
  logic [30:0]         fin_dist, ad79;
  logic                fin_v;

  assign ck79  = rcci_pkg::hit_kind_e'(cap79[33:32]);
  assign ct79  = $signed(cap79[31:0]);
  assign fin_v = vad79[31];
  assign ad79  = vad79[30:0];

  always_comb begin
    priority if (ck79 != rcci_pkg::HIT_NONE
                 && (sk79_q == rcci_pkg::HIT_NONE || ct79 < st79_q)) begin
      fin_kind = ck79;
      fin_dist = ct79[30:0];
    end else if (sk79_q != rcci_pkg::HIT_NONE) begin
      fin_kind = sk79_q;
      fin_dist = st79_q[30:0];
    end else begin
      fin_kind = rcci_pkg::HIT_NONE;
      fin_dist = ad79;
    end
  end

  // output register and skid
  rcci_pkg::hit_kind_e out_kind_q, skid_kind_q;
  logic [30:0]         out_dist_q, skid_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) skid_v_q <= 1'b0;
    end else if (out_v_q && !m_axis_tready) begin
      if (fin_v) skid_v_q <= 1'b1;
    end else begin
      out_v_q <= fin_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) begin
        out_kind_q <= skid_kind_q;
        out_dist_q <= skid_dist_q;
      end
    end else if (out_v_q && !m_axis_tready) begin
      skid_kind_q <= fin_kind;
      skid_dist_q <= fin_dist;
    end else begin
      out_kind_q <= fin_kind;
      out_dist_q <= fin_dist;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_dist_q};
  assign m_axis_tuser  = out_kind_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready && fin_v))
    else $error("skid loaded without an output stall");

  a_hit_nearer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_v && fin_kind != rcci_pkg::HIT_NONE) |-> (fin_dist < ad79))
    else $error("reported hit is not nearer than the input distance");

endmodule

/* verif/ray_capped_cylinder_intersect_checker.sv */
// checker: predicts cylinder hits for accepted rays and compares the returned results
`timescale 1ns / 1ps

module ray_capped_cylinder_intersect_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [223:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [rcci_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int FB = 16;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    rcci_pkg::hit_kind_e kind;
    logic [30:0]         hdist;
  } hit_t;

  longint cx, cy, cz, hh, r2, maxd;
  hit_t   hits_expected[$];

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    longint unsigned m;
    p = a * b;
    m = (p < 0) ? longint'(-p) : p;
    m = m >> FB;
    return (p < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    longint unsigned mn, md, q;
    longint r;
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    q = (mn << FB) / md;
    r = (q > (64'd1 << 40)) ? (64'sd1 << 40) : longint'(q);
    if ((n < 0) != (d < 0)) r = -r;
    return clamp32(r);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic bit within_disc(longint ox, longint oy, longint dx, longint dy, longint t);
    longint px, py;
    px = clamp32(ox + clamp32(fx_mul(dx, t)));
    py = clamp32(oy + clamp32(fx_mul(dy, t)));
    return (fx_mul(px, px) + fx_mul(py, py)) < r2;
  endfunction

  function automatic bit within_height(longint oz, longint dz, longint t);
    longint z;
    z = clamp32(oz + clamp32(fx_mul(t, dz)));
    if (z < 0) z = -z;
    return z <= hh;
  endfunction

  function automatic hit_t cylinder_hit(logic [223:0] d);
    longint ox, oy, oz, dx, dy, dz, near, tf, ts, t2, t3, t0, t1, a, b, c, bb, ac, q;
    longint unsigned disc;
    bit ok;
    rcci_pkg::hit_kind_e capk, sidek;
    hit_t r;
    ox = clamp32(longint'($signed(d[31:0])) - cx);
    oy = clamp32(longint'($signed(d[63:32])) - cy);
    oz = clamp32(longint'($signed(d[95:64])) - cz);
    dx = $signed(d[127:96]);
    dy = $signed(d[159:128]);
    dz = $signed(d[191:160]);
    near = longint'(d[222:192]);
    capk = rcci_pkg::HIT_NONE;
    sidek = rcci_pkg::HIT_NONE;
    tf = maxd;
    ts = maxd;
    if (dz != 0) begin
      t2 = fx_div(hh - oz, dz);
      t3 = fx_div(-hh - oz, dz);
      if (t2 > t3) begin
        t0 = t2; t2 = t3; t3 = t0;
      end
      if (t2 < 0) begin
        if (t3 > 0 && t3 < near && within_disc(ox, oy, dx, dy, t3)) begin
          tf = t3; capk = rcci_pkg::HIT_INSIDE;
        end
      end else if (t2 < near && within_disc(ox, oy, dx, dy, t2)) begin
        tf = t2; capk = rcci_pkg::HIT_OUTSIDE;
      end
    end
    a = clamp32(fx_mul(dx, dx) + fx_mul(dy, dy));
    b = clamp32(fx_mul(ox, dx) + fx_mul(oy, dy));
    c = clamp32(fx_mul(ox, ox) + fx_mul(oy, oy) - r2);
    if (a != 0) begin
      bb = b * b;
      ac = a * c;
      ok = 1;
      disc = 0;
      if (ac <= 0) disc = longint'(bb) + longint'(-ac);
      else if (bb < ac) ok = 0;
      else disc = bb - ac;
      if (ok) begin
        q = longint'(root_floor(disc));
        t0 = fx_div(-b - q, a);
        t1 = fx_div(-b + q, a);
        if (t0 < 0) begin
          if (t1 >= 0 && t1 < near && within_height(oz, dz, t1)) begin
            ts = t1; sidek = rcci_pkg::HIT_INSIDE;
          end
        end else if (t0 < near && within_height(oz, dz, t0)) begin
          ts = t0; sidek = rcci_pkg::HIT_OUTSIDE;
        end
      end
    end
    r.kind = rcci_pkg::HIT_NONE;
    r.hdist = near[30:0];
    if (capk != rcci_pkg::HIT_NONE && (sidek == rcci_pkg::HIT_NONE || tf < ts)) begin
      r.kind = capk; r.hdist = tf[30:0];
    end else if (sidek != rcci_pkg::HIT_NONE) begin
      r.kind = sidek; r.hdist = ts[30:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_t e;
    if (!rst_ni) begin
      cx = 0; cy = 0; cz = 0;
      hh = 64'd65536; r2 = 64'd65536; maxd = 64'h7fffffff;
      hits_expected.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (rcci_pkg::cfg_reg_e'(cfg_addr_i))
          rcci_pkg::REG_CENTER_X:       cx = $signed(cfg_data_i);
          rcci_pkg::REG_CENTER_Y:       cy = $signed(cfg_data_i);
          rcci_pkg::REG_CENTER_Z:       cz = $signed(cfg_data_i);
          rcci_pkg::REG_HALF_HEIGHT:    hh = cfg_data_i[30:0];
          rcci_pkg::REG_RADIUS_SQUARED: r2 = cfg_data_i[30:0];
          rcci_pkg::REG_MAX_DISTANCE:   maxd = cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (hits_expected.size() == 0) begin
          $error("result transaction with no ray pending: kind %0d dist %h",
                 m_axis_tuser, m_axis_tdata);
          fail_count_o++;
        end else begin
          e = hits_expected.pop_front();
          if (m_axis_tuser !== e.kind) begin
            $error("hit_kind: expected %0d actual %0d", e.kind, m_axis_tuser);
            fail_count_o++;
          end
          if (m_axis_tdata[30:0] !== e.hdist) begin
            $error("hit_distance: expected %h actual %h", e.hdist, m_axis_tdata[30:0]);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) hits_expected.push_back(cylinder_hit(s_axis_tdata));
      pending_o = hits_expected.size();
    end
  end

endmodule

/* verif/ray_capped_cylinder_intersect_test.sv */
// testbench top: drives rays and cylinder settings into the intersector and gives the verdict
`timescale 1ns / 1ps

module ray_capped_cylinder_intersect_test;

  localparam int ONE = 65536;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [rcci_pkg::CFG_AW-1:0] cfg_addr_i = '0;
  logic [31:0]  cfg_data_i = '0;
  int           fail_count, pending;
  bit           idle_on = 1'b1;
  int           stall_left = 0;

  always #4 clk_i = ~clk_i;

  ray_capped_cylinder_intersect u_dut (.*);

  ray_capped_cylinder_intersect_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls in random bursts while idle_on is set
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_ray(int ox, int oy, int oz, int dx, int dy, int dz, int nd);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, nd[30:0], dz, dy, dx, oz, oy, ox};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(rcci_pkg::cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  function automatic int span(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  task automatic random_rays(int n, int rad);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        send_ray(span(rad), span(rad), span(rad), span(2 * ONE), span(2 * ONE),
                 ($urandom_range(0, 7) == 0) ? 0 : span(2 * ONE),
                 $urandom_range(0, 31) == 0 ? $urandom_range(0, 4 * ONE)
                                             : $urandom_range(16 * ONE, 32'h7fffffff));
    end
  endtask

  task automatic set_cylinder(int x, int y, int z, int h, int rr, int md);
    write_reg(rcci_pkg::REG_CENTER_X, x);
    write_reg(rcci_pkg::REG_CENTER_Y, y);
    write_reg(rcci_pkg::REG_CENTER_Z, z);
    write_reg(rcci_pkg::REG_HALF_HEIGHT, h);
    write_reg(rcci_pkg::REG_RADIUS_SQUARED, rr);
    write_reg(rcci_pkg::REG_MAX_DISTANCE, md);
  endtask

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int far;
    far = 32'h7fffffff;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rays against the reset cylinder
    send_ray(0, 0, 3 * ONE, 0, 0, -ONE, far);
    send_ray(0, 0, 0, 0, 0, ONE, far);
    send_ray(-3 * ONE, 0, 0, ONE, 0, 0, far);
    send_ray(0, 0, 0, ONE, 0, 0, far);
    send_ray(ONE, 0, 0, -ONE, 0, 0, far);
    send_ray(-3 * ONE, 5 * ONE, 0, ONE, 0, 0, far);
    send_ray(0, -ONE / 2, 3 * ONE, 0, ONE / 10, -ONE, far);
    send_ray(-3 * ONE, 0, 3 * ONE, ONE, 0, -ONE, far);
    send_ray(5 * ONE, 5 * ONE, 3 * ONE, ONE, ONE, -ONE, far);
    send_ray(0, 0, 3 * ONE, 0, 0, -ONE, 0);
    send_ray(0, 0, 3 * ONE, 0, 0, -ONE, 2 * ONE);
    send_ray(-3 * ONE, 0, 0, ONE, 0, 0, 2 * ONE);
    send_ray(0, 0, ONE, ONE, 0, 0, far);
    send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h7fffffff, far);
    send_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h80000000, far);
    send_ray(0, 0, 0, 0, 0, 0, 0);
    send_ray(32'h80000000, 0, 0, 32'h7fffffff, 1, 32'h80000000, far);
    send_ray(-1, 1, -1, -1, 1, -1, 1);
    send_ray(0, 0, -5 * ONE, 1, 0, 1, far);

    random_rays(80, 8 * ONE);
    drain();
    random_rays(20, 4 * ONE);
    drain();

    set_cylinder(span(4 * ONE), span(4 * ONE), span(4 * ONE),
                 $urandom_range(ONE / 2, 4 * ONE), $urandom_range(ONE / 4, 16 * ONE),
                 $urandom_range(0, 32'h7fffffff));
    random_rays(100, 8 * ONE);
    drain();

    set_cylinder(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 32'h7fffffff, 0);
    random_rays(50, 32'h7fffffff);
    drain();

    set_cylinder(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff);
    random_rays(50, 32'h7fffffff);
    drain();

    set_cylinder(0, 0, 0, 32'h7fffffff, 32'h7fffffff, ONE);
    random_rays(50, 64 * ONE);
    drain();

    idle_on = 1'b0;
    set_cylinder(span(2 * ONE), span(2 * ONE), span(2 * ONE),
                 $urandom_range(ONE / 4, 8 * ONE), $urandom_range(ONE / 8, 9 * ONE),
                 $urandom_range(0, 32'h7fffffff));
    random_rays(150, 6 * ONE);
    drain();
    repeat (100) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rcci_pkg.sv
hdl/rcci_delay.sv
hdl/rcci_div.sv
hdl/rcci_sqrt.sv
hdl/ray_capped_cylinder_intersect.sv
verif/ray_capped_cylinder_intersect_checker.sv
verif/ray_capped_cylinder_intersect_test.sv
